// File: rtl/maf_pkg.sv
package maf_pkg;

  // window_len register
  localparam int CFG_BITS         = 7;
  localparam int WINDOW_LEN_RESET = 4;

  // result format
  localparam int FRAC_BITS = 8;
  localparam int OUT_BITS  = 24;

  // control that travels with each word down the divider chain
  typedef struct packed {
    logic valid;
    logic neg;
  } div_ctl_t;

endpackage

// File: rtl/moving_average_filter.sv
// Boxcar moving average over blocks of signed samples.
//
// s_tdata carries one sample per word, s_tuser flags the first sample of a
// new block. Once window_len samples of the block are in, each sample gives
// one word on m_tdata: window sum * 256 / window_len, truncated toward zero,
// 8 fraction bits. window_len is written over cfg_valid/cfg_ready/cfg_data
// (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX) and restarts the
// block; write it only while no words are in flight.
//
// One sample per cycle while the output is not stalled. The last samples sit
// in a row of WINDOW_MAX delay cells; the running sum updates in the accept
// cycle and the quotient comes out of a chain of SAMPLE_BITS +
// clog2(WINDOW_MAX) + 8 restoring divider cells, one quotient bit per cell,
// into a registered output.
//
// The whole pipeline holds while m_tvalid is high and m_tready low, and
// s_tready drops with it. Synchronous reset empties the pipeline, clears the
// sum and fill count and sets window_len to 4; delay cells are not cleared.
module moving_average_filter #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
  input  logic                                s_tuser,  // block_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [maf_pkg::OUT_BITS-1:0]        m_tdata,  // average
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [maf_pkg::CFG_BITS-1:0]        cfg_data  // window_len
);

  localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
  localparam int CMP_BITS = (LEN_BITS > maf_pkg::CFG_BITS) ? LEN_BITS : maf_pkg::CFG_BITS;
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int DIV_BITS = SUM_BITS + maf_pkg::FRAC_BITS;
  localparam int QW       = ((DIV_BITS > maf_pkg::OUT_BITS) ? DIV_BITS : maf_pkg::OUT_BITS) + 1;
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(
      (WINDOW_MAX < maf_pkg::WINDOW_LEN_RESET) ? WINDOW_MAX : maf_pkg::WINDOW_LEN_RESET);
  localparam logic [QW-1:0] POS_LIM = QW'((1 << (maf_pkg::OUT_BITS - 1)) - 1);
  localparam logic [QW-1:0] NEG_LIM = QW'(1 << (maf_pkg::OUT_BITS - 1));

  logic                       advance;
  logic                       accept;
  logic                       cfg_write;
  logic [LEN_BITS-1:0]        eff_len;
  logic [LEN_BITS-1:0]        eff_len_m1;
  logic [LEN_BITS-1:0]        eff_len_next;
  logic [CMP_BITS-1:0]        cfg_ext;
  logic [LEN_BITS-1:0]        fill_count;
  logic [LEN_BITS-1:0]        fill_count_next;
  logic [LEN_BITS-1:0]        fill_base;
  logic signed [SUM_BITS-1:0] window_sum;
  logic signed [SUM_BITS-1:0] window_sum_next;
  logic signed [SUM_BITS-1:0] sum_base;
  logic signed [SUM_BITS-1:0] sample_ext;
  logic signed [SUM_BITS-1:0] old_ext;
  logic                       full;
  logic                       produce;
  logic                       p_valid;
  logic [SUM_BITS-1:0]        sum_u;
  logic [SUM_BITS-1:0]        mag;
  logic [SAMPLE_BITS-1:0]     sample;
  logic [SAMPLE_BITS-1:0]     tap [0:WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      tap_sel;

  maf_pkg::div_ctl_t          div_ctl  [0:DIV_BITS];
  logic [DIV_BITS-1:0]        div_work [0:DIV_BITS];
  logic [LEN_BITS-1:0]        div_rem  [0:DIV_BITS];

  logic [QW-1:0]              qx;
  logic [QW-1:0]              qx_neg;
  logic [maf_pkg::OUT_BITS-1:0] result;
  logic                       o_valid;
  logic [maf_pkg::OUT_BITS-1:0] o_data;

  assign advance   = !o_valid || m_tready;
  assign s_tready  = advance;
  assign accept    = s_tvalid && advance;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;
  assign sample    = s_tdata[SAMPLE_BITS-1:0];

  // window length as used, clamped into 1..WINDOW_MAX
  always_comb begin
    cfg_ext = CMP_BITS'(cfg_data);
    if (cfg_ext == '0) begin
      eff_len_next = LEN_BITS'(1);
    end else if (cfg_ext > CMP_BITS'(WINDOW_MAX)) begin
      eff_len_next = LEN_BITS'(WINDOW_MAX);
    end else begin
      eff_len_next = LEN_BITS'(cfg_ext);
    end
  end

  assign eff_len_m1 = eff_len - 1'b1;

  // delay line: cell 0 holds the sample that leaves the window
  assign tap[WINDOW_MAX] = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_tap
    assign tap_sel[i] = (eff_len_m1 == LEN_BITS'(i));

    maf_tap_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .shift     (accept),
      .load_new  (tap_sel[i]),
      .new_sample(sample),
      .from_next (tap[i+1]),
      .value     (tap[i])
    );
  end

  // running sum; block start restarts before this word is counted
  always_comb begin
    sample_ext      = {{(SUM_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    old_ext         = {{(SUM_BITS-SAMPLE_BITS){tap[0][SAMPLE_BITS-1]}}, tap[0]};
    fill_base       = s_tuser ? '0 : fill_count;
    sum_base        = s_tuser ? '0 : window_sum;
    full            = fill_base >= eff_len;
    fill_count_next = full ? fill_base : fill_base + 1'b1;
    window_sum_next = sum_base + sample_ext - (full ? old_ext : '0);
    produce         = fill_count_next >= eff_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len    <= LEN_RESET;
      fill_count <= '0;
      window_sum <= '0;
      p_valid    <= 1'b0;
    end else begin
      if (advance) begin
        p_valid <= accept && produce;
      end
      if (accept) begin
        fill_count <= fill_count_next;
        window_sum <= window_sum_next;
      end
      if (cfg_write) begin
        eff_len    <= eff_len_next;
        fill_count <= '0;
        window_sum <= '0;
      end
    end
  end

  // divide |sum| * 256 by the window length, one quotient bit per cell
  assign sum_u = window_sum;
  assign mag   = window_sum[SUM_BITS-1] ? (~sum_u + 1'b1) : sum_u;

  assign div_ctl[0]  = '{valid: p_valid, neg: window_sum[SUM_BITS-1]};
  assign div_work[0] = {mag, {maf_pkg::FRAC_BITS{1'b0}}};
  assign div_rem[0]  = '0;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    maf_div_cell #(
      .DIV_BITS(DIV_BITS),
      .LEN_BITS(LEN_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .divisor (eff_len),
      .in_ctl  (div_ctl[k]),
      .in_work (div_work[k]),
      .in_rem  (div_rem[k]),
      .out_ctl (div_ctl[k+1]),
      .out_work(div_work[k+1]),
      .out_rem (div_rem[k+1])
    );
  end

  // sign back on, saturate to the output range
  always_comb begin
    qx     = QW'(div_work[DIV_BITS]);
    qx_neg = ~qx + 1'b1;
    if (div_ctl[DIV_BITS].neg) begin
      result = (qx > NEG_LIM) ? NEG_LIM[maf_pkg::OUT_BITS-1:0]
                              : qx_neg[maf_pkg::OUT_BITS-1:0];
    end else begin
      result = (qx > POS_LIM) ? POS_LIM[maf_pkg::OUT_BITS-1:0]
                              : qx[maf_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= div_ctl[DIV_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_data <= result;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

endmodule

// File: rtl/maf_tap_cell.sv
module maf_tap_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   shift,
  input  logic                   load_new,
  input  logic [SAMPLE_BITS-1:0] new_sample,
  input  logic [SAMPLE_BITS-1:0] from_next,
  output logic [SAMPLE_BITS-1:0] value
);

  // the cell at the window's far end takes the fresh sample, the others
  // move one place toward cell 0
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= load_new ? new_sample : from_next;
    end
  end

endmodule

// File: rtl/maf_div_cell.sv
module maf_div_cell #(
  parameter int DIV_BITS = 30,
  parameter int LEN_BITS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [LEN_BITS-1:0]  divisor,
  input  maf_pkg::div_ctl_t    in_ctl,
  input  logic [DIV_BITS-1:0]  in_work,
  input  logic [LEN_BITS-1:0]  in_rem,
  output maf_pkg::div_ctl_t    out_ctl,
  output logic [DIV_BITS-1:0]  out_work,
  output logic [LEN_BITS-1:0]  out_rem
);

  logic [LEN_BITS:0]   trial;
  logic [LEN_BITS:0]   diff;
  logic                ge;
  logic [LEN_BITS-1:0] rem_next;
  logic [DIV_BITS-1:0] work_next;

  // one restoring step: dividend bits leave at the top, quotient bits
  // enter at the bottom
  always_comb begin
    trial     = {in_rem, in_work[DIV_BITS-1]};
    diff      = trial - {1'b0, divisor};
    ge        = trial >= {1'b0, divisor};
    rem_next  = ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
    work_next = {in_work[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (advance) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_work <= work_next;
      out_rem  <= rem_next;
    end
  end

endmodule

// File: rtl/maf_checker.sv
module maf_assertions (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [maf_pkg::OUT_BITS-1:0] m_tdata,
  input logic                         cfg_ready
);

  // a waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a stalled output stalls the input side too
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // with no word waiting, the block takes input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready && cfg_ready)
    else $error("block not ready with output empty");

endmodule

bind moving_average_filter maf_assertions u_maf_assertions (.*);

// File: test/maf_checker.sv
module maf_checker #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [SAMPLE_BITS-1:0]       s_tdata,   // sample
  input  logic                         s_tuser,   // block_start
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [maf_pkg::OUT_BITS-1:0] m_tdata,   // average
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [maf_pkg::CFG_BITS-1:0] cfg_data,  // window_len
  output int                           errors,
  output int                           pending
);

  localparam longint AVG_MAX = (longint'(1) << (maf_pkg::OUT_BITS - 1)) - 1;
  localparam longint AVG_MIN = -(longint'(1) << (maf_pkg::OUT_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
  longint                        run_sum;
  int unsigned                   fill;
  int unsigned                   wr_ptr;
  logic [maf_pkg::CFG_BITS-1:0]  win_reg;
  logic [maf_pkg::OUT_BITS-1:0]  expected_averages [$];
  logic [maf_pkg::OUT_BITS-1:0]  exp_avg;

  function automatic int unsigned span_of(logic [maf_pkg::CFG_BITS-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return 32'(w);
  endfunction

  task automatic take_sample(logic signed [SAMPLE_BITS-1:0] smp, logic start);
    int unsigned len;
    int unsigned oldest;
    longint      quot;
    len = span_of(win_reg);
    if (start) begin
      fill    = 0;
      run_sum = 0;
    end
    if (fill >= len) begin
      // window full: the sample len words back drops out
      oldest  = (wr_ptr + WINDOW_MAX - len) % WINDOW_MAX;
      run_sum = run_sum - longint'(history[oldest]);
    end else begin
      fill++;
    end
    run_sum         = run_sum + longint'(smp);
    history[wr_ptr] = smp;
    wr_ptr          = (wr_ptr + 1) % WINDOW_MAX;
    if (fill >= len) begin
      // signed division truncates toward zero
      quot = (run_sum * (longint'(1) << maf_pkg::FRAC_BITS)) / longint'(len);
      if (quot > AVG_MAX) quot = AVG_MAX;
      if (quot < AVG_MIN) quot = AVG_MIN;
      expected_averages.push_back(quot[maf_pkg::OUT_BITS-1:0]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_MAX; i++) history[i] = '0;
      run_sum = 0;
      fill    = 0;
      wr_ptr  = 0;
      win_reg = maf_pkg::CFG_BITS'(maf_pkg::WINDOW_LEN_RESET);
      expected_averages.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_reg = cfg_data;
        fill    = 0;
        run_sum = 0;
      end
      if (s_tvalid && s_tready) take_sample(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_averages.size() == 0) begin
          $error("average: no word expected, got %0d", $signed(m_tdata));
          errors++;
        end else begin
          exp_avg = expected_averages.pop_front();
          if (m_tdata !== exp_avg) begin
            $error("average: expected %0d, got %0d", $signed(exp_avg), $signed(m_tdata));
            errors++;
          end
        end
      end
    end
    pending <= expected_averages.size();
  end

endmodule

// File: test/tb_moving_average_filter.sv
module tb_moving_average_filter;

  localparam int WINDOW_MAX      = 64;
  localparam int SAMPLE_BITS     = 16;
  localparam int SDATA_BITS      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DRAIN_CYCLES    = 40;   // time for the pipeline to drain
  localparam int PRESSURE_CYCLES = 200;

  logic                         clk;
  logic                         rst       = 1'b1;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [SDATA_BITS-1:0]        s_tdata   = '0;
  logic                         s_tuser   = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [maf_pkg::OUT_BITS-1:0] m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [maf_pkg::CFG_BITS-1:0] cfg_data  = '0;

  int errors;
  int pending;
  bit tx_steady;
  bit rx_steady;
  bit pressure_req;
  int rx_hold;
  int span;

  moving_average_filter #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  maf_checker #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata[SAMPLE_BITS-1:0]),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_moving_average_filter: FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // result side back-pressure
  initial begin
    rx_hold = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        rx_hold      = PRESSURE_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (rx_steady) begin
        m_tready <= 1'b1;
      end else begin
        rx_hold = idle_len();
        m_tready <= (rx_hold == 0);
        if (rx_hold > 0) rx_hold--;
      end
    end
  end

  // valid stays up across back-to-back words; only a gap lowers it
  task automatic push_sample(logic [SAMPLE_BITS-1:0] smp, logic start);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SDATA_BITS'(smp);
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_window(logic [maf_pkg::CFG_BITS-1:0] w);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // samples that make no result may still be in the divider chain
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (w == 0) span = 1;
    else if (w > WINDOW_MAX) span = WINDOW_MAX;
    else span = w;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int flavor);
    logic [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    case (flavor)
      1: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      3: v = SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: begin
        if ($urandom_range(0, 9) == 0) v = {v[SAMPLE_BITS-1], {(SAMPLE_BITS-1){~v[SAMPLE_BITS-1]}}};
      end
    endcase
    return v;
  endfunction

  // blocks of random length: most reach the window, some are cut short
  task automatic run_blocks(int n_items);
    int done;
    int blk;
    int r;
    int flavor;
    bit first;
    logic start;
    done  = 0;
    first = 1'b1;
    while (done < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 7) blk = span + $urandom_range(0, span + 8);
      else if (r < 9) blk = $urandom_range(1, span);
      else blk = $urandom_range(1, 3 * span + 4);
      r = $urandom_range(0, 9);
      flavor = (r < 6) ? 0 : (r < 7) ? 1 : (r < 8) ? 2 : 3;
      for (int i = 0; i < blk; i++) begin
        if (i == 0) start = first ? 1'($urandom_range(0, 1)) : 1'b1;
        else start = ($urandom_range(0, 59) == 0);
        push_sample(pick_sample(flavor), start);
      end
      first = 1'b0;
      done += blk;
    end
  endtask

  initial begin
    logic [maf_pkg::CFG_BITS-1:0] windows [12];
    int                           counts  [12];
    span = maf_pkg::WINDOW_LEN_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of 4: full-scale positive and negative, then a restart mid-fill
    repeat (5) push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b1);
    repeat (4) push_sample(16'h8000, 1'b0);
    push_sample(16'h0001, 1'b1);
    push_sample(16'hffff, 1'b0);
    push_sample(16'h0003, 1'b1);
    push_sample(16'h0005, 1'b0);
    push_sample(16'h0007, 1'b0);
    push_sample(16'h0009, 1'b0);
    push_sample(16'h0000, 1'b0);
    // window of 3: quotients that truncate toward zero, no block flag after the write
    write_window(7'd3);
    push_sample(16'hffff, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'hfffe, 1'b0);

    windows = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd3, 7'd7,
                7'd0, 7'd64, 7'd2, 7'd33, 7'd0};
    counts  = '{70, 100, 70, 100, 100, 70, 70, 70, 100, 70, 70, 70};
    windows[7]  = maf_pkg::CFG_BITS'($urandom_range(1, WINDOW_MAX));
    windows[11] = maf_pkg::CFG_BITS'($urandom_range(1, 16));
    for (int p = 0; p < 12; p++) begin
      write_window(windows[p]);
      if (p == 2) begin
        // receiver stalls long while the sender keeps offering
        tx_steady    = 1'b1;
        rx_steady    = 1'b0;
        pressure_req = 1'b1;
      end else begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      run_blocks(counts[p]);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_moving_average_filter: PASS");
    end else begin
      $display("tb_moving_average_filter: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/maf_pkg.sv
rtl/maf_tap_cell.sv
rtl/maf_div_cell.sv
rtl/moving_average_filter.sv
rtl/maf_checker.sv
test/maf_checker.sv
test/tb_moving_average_filter.sv
